// ----- rtl/core/gnbm_pkg.sv -----
// gnbm_pkg: shared types, codes and constants of the nearest box label matcher
// used by gnbm_dist and the top level greedy_nearest_box_label_match_core

package gnbm_pkg;

    // table capacity default and field widths
    localparam int MAX_BOXES_DEF = 64;
    localparam int IDX_MAX_W     = 8;
    localparam int COORD_W       = 12;
    localparam int LABEL_W       = 16;
    localparam int PIX_W         = 16;
    localparam int DIM_W         = 13;
    localparam int ABS_W         = 17;
    localparam int SQ_W          = 2 * ABS_W;
    localparam int DIST_W        = SQ_W + 1;
    localparam int OUT_IDX_W     = 6;
    localparam int ENTRY_W       = LABEL_W + 2 * COORD_W;

    // stream payload widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int CFG_ADDR_W = 1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    // request kinds
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    // query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // tag that travels with each table entry through the distance pipeline
    typedef struct packed {
        logic               live;
        logic               cand;
        logic [LABEL_W-1:0] label;
    } dist_tag_t;

endpackage

// ----- rtl/core/greedy_nearest_box_label_match_core.sv -----
// greedy_nearest_box_label_match_core: top level, request decode, scan sequencer,
// used marks and best tracker; depends on gnbm_pkg, gnbm_ram and gnbm_dist
//
// A clear transfer empties the box table, a load transfer appends one box (ignored
// once MAX_BOXES boxes are held), and a query transfer returns one result: the
// nearest unused box center, which is then marked used until the next clear, or
// no match. A query that is out of the image, not in front, or meets an empty table
// goes straight to the result state; otherwise the scan reads the box table through
// its single read port, one entry per cycle, into a three stage distance pipeline,
// which then drains before the result is registered.
// The next transfer is taken while a result still waits on m_tready.
// Box centers are computed at load time and stored in the table.

module greedy_nearest_box_label_match_core import gnbm_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wdata,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_min_x[11:0], box_max_x[23:12], box_min_y[35:24], box_max_y[47:36],
    // box_label[63:48], pixel_x[79:64], pixel_y[95:80], in_front[96], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // matched[0], label[16:1], box_index[22:17], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic [CW-1:0]            count_reg;
    logic [MAX_BOXES-1:0]     used_reg;
    logic [AW-1:0]            scan_idx_reg;
    logic signed [PIX_W-1:0]  px_reg;
    logic signed [PIX_W-1:0]  py_reg;
    logic                     rd_live_reg;
    logic                     rd_cand_reg;
    logic [AW-1:0]            rd_idx_reg;
    logic                     best_found_reg;
    logic [DIST_W-1:0]        best_dist_reg;
    logic [AW-1:0]            best_idx_reg;
    logic [LABEL_W-1:0]       best_label_reg;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    req_t                     req;
    logic                     s_fire;
    logic                     in_bounds;
    logic                     in_front;
    logic signed [PIX_W-1:0]  pixel_x;
    logic signed [PIX_W-1:0]  pixel_y;
    logic                     query_go;
    logic                     query_nogo;
    logic                     room;
    logic                     load_fire;
    logic                     clear_fire;
    logic                     out_free;
    logic                     done_fire;
    logic                     scan_last;
    logic [COORD_W:0]         sum_x;
    logic [COORD_W:0]         sum_y;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    dist_tag_t                rd_tag;
    dist_tag_t                dist_tag;
    logic [AW-1:0]            dist_idx;
    logic [DIST_W-1:0]        cand_dist;
    logic                     dist_busy;
    logic                     better;
    logic [IDX_MAX_W-1:0]     idx_ext;

    // request decode and bounds check
    always_comb begin
        req        = req_t'(s_tuser);
        s_fire     = s_tvalid && s_tready;
        pixel_x    = $signed(s_tdata[79:64]);
        pixel_y    = $signed(s_tdata[95:80]);
        in_front   = s_tdata[96];
        in_bounds  = !pixel_x[PIX_W-1] && !pixel_y[PIX_W-1]
                     && ({2'b00, pixel_x[PIX_W-2:0]} < {width_reg, 4'b0000})
                     && ({2'b00, pixel_y[PIX_W-2:0]} < {height_reg, 4'b0000});
        room       = count_reg < CW'(MAX_BOXES);
        clear_fire = s_fire && (req == REQ_CLEAR);
        load_fire  = s_fire && (req == REQ_LOAD) && room;
        query_go   = s_fire && (req == REQ_QUERY) && in_front && in_bounds
                     && (count_reg != '0);
        query_nogo = s_fire && (req == REQ_QUERY) && !query_go;
        out_free   = !m_valid_reg || m_tready;
        scan_last  = CW'(scan_idx_reg) == (count_reg - CW'(1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_go) begin
                    state_next = ST_SCAN;
                end else if (query_nogo) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_live_reg && !dist_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        done_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SCAN:  s_tready  = 1'b0;
            ST_DRAIN: s_tready  = 1'b0;
            ST_DONE:  done_fire = out_free;
            default: begin
                s_tready  = 1'b0;
                done_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // box count and used marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            used_reg  <= '0;
        end else begin
            if (clear_fire) begin
                count_reg <= '0;
                used_reg  <= '0;
            end else if (load_fire) begin
                count_reg <= count_reg + CW'(1);
                used_reg[count_reg[AW-1:0]] <= 1'b0;
            end else if (done_fire && best_found_reg) begin
                used_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // box table holds centers and label, written at load
    always_comb begin
        sum_x     = {1'b0, s_tdata[11:0]} + {1'b0, s_tdata[23:12]};
        sum_y     = {1'b0, s_tdata[35:24]} + {1'b0, s_tdata[47:36]};
        ram_wdata = {s_tdata[63:48], sum_y[COORD_W:1], sum_x[COORD_W:1]};
    end

    gnbm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .aclk  (aclk),
        .we    (load_fire),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // scan address and query point
    always_ff @(posedge aclk) begin
        if (query_go) begin
            scan_idx_reg <= '0;
            px_reg       <= pixel_x;
            py_reg       <= pixel_y;
        end else if (state_reg == ST_SCAN) begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
        rd_cand_reg <= !used_reg[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;
    end

    // read slot occupancy, aligned with table read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_live_reg <= 1'b0;
        end else begin
            rd_live_reg <= (state_reg == ST_SCAN);
        end
    end

    always_comb begin
        rd_tag.live  = rd_live_reg;
        rd_tag.cand  = rd_cand_reg;
        rd_tag.label = ram_rdata[ENTRY_W-1 -: LABEL_W];
    end

    gnbm_dist #(
        .AW (AW)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cx       (ram_rdata[COORD_W-1:0]),
        .cy       (ram_rdata[2*COORD_W-1:COORD_W]),
        .px       (px_reg),
        .py       (py_reg),
        .in_tag   (rd_tag),
        .in_idx   (rd_idx_reg),
        .out_tag  (dist_tag),
        .out_idx  (dist_idx),
        .out_dist (cand_dist),
        .busy     (dist_busy)
    );

    // best candidate, strict less-than keeps the lowest index on a tie
    assign better = dist_tag.live && dist_tag.cand
                    && (!best_found_reg || (cand_dist < best_dist_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (s_fire && (req == REQ_QUERY)) begin
            best_found_reg <= 1'b0;
        end else if (better) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (better) begin
            best_dist_reg  <= cand_dist;
            best_idx_reg   <= dist_idx;
            best_label_reg <= dist_tag.label;
        end
    end

    // result register
    assign idx_ext = IDX_MAX_W'(best_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            if (best_found_reg) begin
                m_data_reg <= {1'b0, idx_ext[OUT_IDX_W-1:0], best_label_reg, 1'b1};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // scan never reads past the loaded boxes
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CW'(scan_idx_reg) < count_reg))
        else $error("scan address beyond box count");

    // the distance pipeline is empty whenever a new transfer can be taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_live_reg && !dist_busy))
        else $error("distance pipeline busy while idle");

    // a chosen box is a loaded, unused one
    a_best_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && best_found_reg)
        |-> ((CW'(best_idx_reg) < count_reg) && !used_reg[best_idx_reg]))
        else $error("chosen box not loaded or already used");

    // an assigned box is marked used once the result is registered
    a_mark_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_fire && best_found_reg) |=> used_reg[$past(best_idx_reg)])
        else $error("assigned box not marked used");

endmodule

// ----- rtl/core/gnbm_ram.sv -----
// gnbm_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module gnbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/gnbm_dist.sv -----
// gnbm_dist: three stage squared distance pipeline, center to query point
// depends on gnbm_pkg

module gnbm_dist import gnbm_pkg::*; #(
    parameter int AW = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [COORD_W-1:0]       cx,
    input  logic [COORD_W-1:0]       cy,
    input  logic signed [PIX_W-1:0]  px,
    input  logic signed [PIX_W-1:0]  py,
    input  dist_tag_t                in_tag,
    input  logic [AW-1:0]            in_idx,
    output dist_tag_t                out_tag,
    output logic [AW-1:0]            out_idx,
    output logic [DIST_W-1:0]        out_dist,
    output logic                     busy
);

    logic signed [ABS_W:0] dx;
    logic signed [ABS_W:0] dy;
    logic [ABS_W-1:0]      ax_reg;
    logic [ABS_W-1:0]      ay_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    dist_tag_t             tag1_reg;
    dist_tag_t             tag2_reg;
    dist_tag_t             tag3_reg;
    logic [AW-1:0]         idx1_reg;
    logic [AW-1:0]         idx2_reg;
    logic [AW-1:0]         idx3_reg;
    logic [DIST_W-1:0]     dist_reg;

    // center in q.4 minus point, both axes
    always_comb begin
        dx = $signed({2'b00, cx, 4'b0000}) - $signed({{2{px[PIX_W-1]}}, px});
        dy = $signed({2'b00, cy, 4'b0000}) - $signed({{2{py[PIX_W-1]}}, py});
    end

    // stage payload (magnitude, square, sum) and stage occupancy
    always_ff @(posedge aclk) begin
        ax_reg   <= dx[ABS_W] ? ABS_W'(-dx) : ABS_W'(dx);
        ay_reg   <= dy[ABS_W] ? ABS_W'(-dy) : ABS_W'(dy);
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        tag1_reg.cand  <= in_tag.cand;
        tag1_reg.label <= in_tag.label;
        tag2_reg.cand  <= tag1_reg.cand;
        tag2_reg.label <= tag1_reg.label;
        tag3_reg.cand  <= tag2_reg.cand;
        tag3_reg.label <= tag2_reg.label;
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        if (!aresetn) begin
            tag1_reg.live <= 1'b0;
            tag2_reg.live <= 1'b0;
            tag3_reg.live <= 1'b0;
        end else begin
            tag1_reg.live <= in_tag.live;
            tag2_reg.live <= tag1_reg.live;
            tag3_reg.live <= tag2_reg.live;
        end
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = dist_reg;
    assign busy     = tag1_reg.live | tag2_reg.live | tag3_reg.live;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for greedy_nearest_box_label_match_core
// depends on gnbm_pkg and the core RTL; drives requests and settings, checks every result

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gnbm_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int TARGET_ITEMS  = 1050;
    localparam int CALM_ITEMS    = 150;
    localparam int TABLE_DEPTH   = MAX_BOXES_DEF;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // one request transfer, unpacked
    typedef struct {
        logic [1:0]               kind;
        logic [COORD_W-1:0]       min_x;
        logic [COORD_W-1:0]       max_x;
        logic [COORD_W-1:0]       min_y;
        logic [COORD_W-1:0]       max_y;
        logic [LABEL_W-1:0]       label;
        logic signed [PIX_W-1:0]  px;
        logic signed [PIX_W-1:0]  py;
        logic                     front;
    } request_t;

    // one result transfer
    typedef struct {
        bit                       matched;
        logic [LABEL_W-1:0]       label;
        logic [OUT_IDX_W-1:0]     index;
    } match_t;

    typedef struct {
        logic [COORD_W-1:0]       min_x;
        logic [COORD_W-1:0]       max_x;
        logic [COORD_W-1:0]       min_y;
        logic [COORD_W-1:0]       max_y;
        logic [LABEL_W-1:0]       label;
    } stored_box_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // predicted block state
    stored_box_t box_store [TABLE_DEPTH];
    bit          box_taken [TABLE_DEPTH];
    int          boxes_held = 0;
    int          img_w = 640;
    int          img_h = 480;
    match_t      pending_matches [$];

    int fail_count     = 0;
    int items_sent     = 0;
    int queries_sent   = 0;
    int results_seen   = 0;
    int matches_seen   = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit tx_gaps_on     = 1'b0;
    bit rx_stalls_on   = 1'b0;

    greedy_nearest_box_label_match_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // nearest unused box for a query, marks the winner as taken
    function automatic match_t nearest_unused_box(request_t r);
        match_t res;
        int     cx;
        int     cy;
        longint dx;
        longint dy;
        longint d;
        longint best_d;
        int     best;
        bit     found;
        res = '{1'b0, '0, '0};
        found = 1'b0;
        best = 0;
        best_d = 0;
        if (!r.front || r.px < 0 || r.py < 0 || r.px >= img_w * 16 || r.py >= img_h * 16)
            return res;
        for (int i = 0; i < boxes_held; i++) begin
            if (box_taken[i])
                continue;
            cx = ((int'(box_store[i].max_x) + int'(box_store[i].min_x)) / 2) * 16;
            cy = ((int'(box_store[i].max_y) + int'(box_store[i].min_y)) / 2) * 16;
            dx = cx - r.px;
            dy = cy - r.py;
            d = dx * dx + dy * dy;
            // strict less-than keeps the lowest index on a tie
            if (!found || d < best_d) begin
                found = 1'b1;
                best = i;
                best_d = d;
            end
        end
        if (found) begin
            box_taken[best] = 1'b1;
            res.matched = 1'b1;
            res.label = box_store[best].label;
            res.index = best[OUT_IDX_W-1:0];
        end
        return res;
    endfunction

    // update the predicted state with one accepted request
    task automatic apply_request(request_t r);
        match_t m;
        case (r.kind)
            REQ_CLEAR: begin
                boxes_held = 0;
                foreach (box_taken[i]) box_taken[i] = 1'b0;
            end
            REQ_LOAD: begin
                // loads past capacity are dropped
                if (boxes_held < TABLE_DEPTH) begin
                    box_store[boxes_held] = '{r.min_x, r.max_x, r.min_y, r.max_y, r.label};
                    box_taken[boxes_held] = 1'b0;
                    boxes_held++;
                end
            end
            REQ_QUERY: begin
                m = nearest_unused_box(r);
                pending_matches.insert(pending_matches.size(), m);
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // request with every field random
    function automatic request_t make_request(logic [1:0] kind);
        request_t r;
        r.kind  = kind;
        r.min_x = COORD_W'($urandom);
        r.max_x = COORD_W'($urandom);
        r.min_y = COORD_W'($urandom);
        r.max_y = COORD_W'($urandom);
        r.label = LABEL_W'($urandom);
        r.px    = PIX_W'($urandom);
        r.py    = PIX_W'($urandom);
        r.front = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic request_t make_box(int x0, int x1, int y0, int y1, int lbl);
        request_t r;
        r = make_request(REQ_LOAD);
        r.min_x = x0[COORD_W-1:0];
        r.max_x = x1[COORD_W-1:0];
        r.min_y = y0[COORD_W-1:0];
        r.max_y = y1[COORD_W-1:0];
        r.label = lbl[LABEL_W-1:0];
        return r;
    endfunction

    function automatic request_t make_point(int x, int y, bit front);
        request_t r;
        r = make_request(REQ_QUERY);
        r.px = x[PIX_W-1:0];
        r.py = y[PIX_W-1:0];
        r.front = front;
        return r;
    endfunction

    // mostly well-formed queries: near a stored center or anywhere in the image
    function automatic request_t make_query();
        request_t    r;
        stored_box_t b;
        int          roll;
        int          lim_x;
        int          lim_y;
        r = make_request(REQ_QUERY);
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            r.front = 1'b1;
            if (boxes_held > 0 && roll < 35) begin
                b = box_store[$urandom_range(0, boxes_held - 1)];
                r.px = PIX_W'(((int'(b.max_x) + int'(b.min_x)) / 2) * 16
                              + int'($urandom_range(0, 32)) - 16);
                r.py = PIX_W'(((int'(b.max_y) + int'(b.min_y)) / 2) * 16
                              + int'($urandom_range(0, 32)) - 16);
            end else begin
                lim_x = (img_w * 16 > 32768) ? 32768 : img_w * 16;
                lim_y = (img_h * 16 > 32768) ? 32768 : img_h * 16;
                r.px = PIX_W'($urandom_range(0, lim_x - 1));
                r.py = PIX_W'($urandom_range(0, lim_y - 1));
            end
        end
        return r;
    endfunction

    // one request transfer, called at a falling edge, returns at a falling edge
    task automatic send_item(request_t r);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {7'd0, r.front, r.py, r.px, r.label, r.max_y, r.min_y, r.max_x, r.min_x};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        apply_request(r);
        items_sent++;
    endtask

    // hold the sender until every result is in and the block has settled
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write both image size registers while the block is idle
    task automatic write_setting(int w, int h);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= w[DIM_W-1:0];
        @(negedge aclk);
        cfg_addr  <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h[DIM_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        img_w = w;
        img_h = h;
        settings_used++;
    endtask

    function automatic int pick_box_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)  return 0;
        if (roll < 70) return $urandom_range(1, 10);
        if (roll < 85) return $urandom_range(11, 40);
        return $urandom_range(60, 70);
    endfunction

    // clear, load boxes, then queries with a little noise mixed in
    task automatic run_frame(int n_boxes, int n_queries);
        int roll;
        send_item(make_request(REQ_CLEAR));
        for (int i = 0; i < n_boxes; i++)
            send_item(make_request(REQ_LOAD));
        for (int i = 0; i < n_queries; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_item(make_request(REQ_UNKNOWN));
            else if (roll < 8)
                send_item(make_request(REQ_LOAD));
            else
                send_item(make_query());
        end
    endtask

    // edges of the fields, ties, crossed boxes, bounds and unknown requests
    task automatic test_directed_edges();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        send_item(make_point(100, 100, 1'b1));
        send_item(make_request(REQ_CLEAR));
        send_item(make_box(0, 4095, 4095, 0, 16'hFFFF));
        send_item(make_box(0, 0, 0, 0, 16'h0000));
        send_item(make_box(300, 100, 200, 50, 16'h1234));
        send_item(make_box(2047, 2047, 2047, 2047, 16'hAAAA));
        send_item(make_request(REQ_UNKNOWN));
        send_item(make_point(-1, 100, 1'b1));
        send_item(make_point(640 * 16, 100, 1'b1));
        send_item(make_point(0, 0, 1'b0));
        send_item(make_point(0, 0, 1'b1));
        send_item(make_point(640 * 16 - 1, 480 * 16 - 1, 1'b1));
        send_item(make_point(32767, 32767, 1'b1));
        send_item(make_point(-32768, -32768, 1'b1));
    endtask

    // largest and smallest image sizes, tie on equal centers, exhausted table
    task automatic test_image_size_extremes();
        write_setting(4096, 4096);
        send_item(make_point(32767, 32767, 1'b1));
        send_item(make_point(32767, 32767, 1'b1));
        send_item(make_point(32767, 32767, 1'b1));
        send_item(make_request(REQ_CLEAR));
        write_setting(1, 1);
        send_item(make_box(0, 0, 0, 0, 16'h5A5A));
        send_item(make_point(15, 15, 1'b1));
        send_item(make_point(16, 0, 1'b1));
        send_item(make_point(0, 16, 1'b1));
    endtask

    // fill past capacity, then use up every box and one more
    task automatic test_table_capacity();
        request_t r;
        write_setting(4096, 4096);
        send_item(make_request(REQ_CLEAR));
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_item(make_request(REQ_LOAD));
        for (int i = 0; i < TABLE_DEPTH + 1; i++) begin
            r = make_request(REQ_QUERY);
            r.front = 1'b1;
            r.px = PIX_W'($urandom_range(0, 32767));
            r.py = PIX_W'($urandom_range(0, 32767));
            send_item(r);
        end
    endtask

    // random frames under idling, with image size changes between phases
    task automatic test_random_frames();
        int frame_no;
        int n;
        frame_no = 0;
        while (items_sent < TARGET_ITEMS - CALM_ITEMS) begin
            if (frame_no % 6 == 5) begin
                case ($urandom_range(0, 5))
                    0: write_setting(4096, 4096);
                    1: write_setting(1, 1);
                    2: write_setting(640, 480);
                    3: write_setting(4095, 1);
                    4: write_setting(1, 4096);
                    default: write_setting($urandom_range(1, 4096), $urandom_range(1, 4096));
                endcase
            end else if ($urandom_range(0, 9) == 0) begin
                wait_all_results();
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            n = pick_box_count();
            run_frame(n, $urandom_range(1, n + 4));
            frame_no++;
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        int n;
        write_setting(640, 480);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        while (items_sent < TARGET_ITEMS) begin
            n = $urandom_range(1, 12);
            run_frame(n, $urandom_range(1, n + 4));
        end
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // result receiver readiness, random stall bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        match_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_matches.size() == 0) begin
                note_failure($sformatf("result with no query pending, tdata %h", m_tdata));
            end else begin
                want = pending_matches.pop_front();
                if (want.matched)
                    matches_seen++;
                if (m_tdata[0] !== want.matched || m_tdata[16:1] !== want.label ||
                    m_tdata[22:17] !== want.index)
                    note_failure($sformatf(
                        "result %0d: expected matched %0b label %h index %0d, got %0b %h %0d",
                        results_seen, want.matched, want.label, want.index,
                        m_tdata[0], m_tdata[16:1], m_tdata[22:17]));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_matches.size());
            $display("FAIL greedy_nearest_box_label_match_core");
            $finish;
        end
    end

    initial begin
        foreach (box_taken[i]) box_taken[i] = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_edges();
        test_image_size_extremes();
        test_table_capacity();
        test_random_frames();
        test_steady_stream();

        wait_all_results();
        $display("covered %0d request transfers, %0d queries, %0d results, %0d matches",
                 items_sent, queries_sent, results_seen, matches_seen);
        $display("%0d image size settings incl. extremes; capacity, ties, bounds, unknown kinds",
                 settings_used);
        if (fail_count == 0) begin
            $display("PASS greedy_nearest_box_label_match_core");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL greedy_nearest_box_label_match_core");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gnbm_pkg.sv
rtl/core/gnbm_ram.sv
rtl/core/gnbm_dist.sv
rtl/core/greedy_nearest_box_label_match_core.sv
tb/tb_top.sv
